FILE: sv/sim_pkg.sv
// ----------------------------------------------------------------------------
// sim_pkg: shared types and constants of the sorted interval map
// Holds the response status codes, the request kinds, the cell command set
// and the control and flag bundles that pass between the table cells.
// ----------------------------------------------------------------------------
package sim_pkg;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_REPLACED = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_HIT      = 3'd3;
   localparam logic [2:0] ST_MISS     = 3'd4;
   localparam logic [2:0] ST_OVERFLOW = 3'd5;

   localparam logic REQ_ADD    = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   localparam int GATHER_GROUP = 32;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_COMPARE,
      OP_INSERT,
      OP_REPLACE,
      OP_SHIFT,
      OP_SELECT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic [63:0] addr;
      logic [63:0] range_end;
   } cell_ctl_type;

   typedef struct packed {
      logic pos;
      logic ovl;
      logic le;
      logic mark;
      logic above;
   } cell_flags_type;

endpackage

FILE: sv/sim_cell.sv
// ----------------------------------------------------------------------------
// sim_cell: one entry of the interval table
// Holds one range and its id, compares it against the broadcast request and
// moves its entry to or from a neighbor on insert and compaction steps.
// ----------------------------------------------------------------------------
module sim_cell #(
   parameter int IDX     = 0,
   parameter int ID_BITS = 16,
   parameter int CW      = 7
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sim_pkg::cell_ctl_type   ctl,
   input  logic [ID_BITS-1:0]      tag,
   input  logic [CW-1:0]           count,
   input  sim_pkg::cell_flags_type lo_flags,
   input  logic [63:0]             lo_start,
   input  logic [63:0]             lo_end,
   input  logic [ID_BITS-1:0]      lo_id,
   input  sim_pkg::cell_flags_type up_flags,
   input  logic [63:0]             up_start,
   input  logic [63:0]             up_end,
   input  logic [ID_BITS-1:0]      up_id,
   output sim_pkg::cell_flags_type flags,
   output logic [63:0]             range_start,
   output logic [63:0]             range_end,
   output logic [ID_BITS-1:0]      range_id,
   output logic                    sel_hit,
   output logic [63:0]             sel_start,
   output logic [63:0]             sel_end,
   output logic [ID_BITS-1:0]      sel_id
);
   import sim_pkg::*;

   logic [63:0]        start_ff;
   logic [63:0]        end_ff;
   logic [ID_BITS-1:0] id_ff;
   logic               v_ff;
   logic               endgt_ff;
   logic               stlt_ff;
   logic               le_ff;
   logic               mark_ff;
   logic               above_ff;
   logic               hit_ff;
   logic               valid;
   logic               first_ovl;

   assign valid       = CW'(IDX) < count;
   assign flags.pos   = !v_ff || endgt_ff;
   assign flags.ovl   = v_ff && endgt_ff && stlt_ff;
   assign flags.le    = le_ff;
   assign flags.mark  = mark_ff;
   assign flags.above = above_ff;
   assign first_ovl   = flags.ovl && !lo_flags.ovl;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= 1'b0;
         endgt_ff <= 1'b0;
         stlt_ff  <= 1'b0;
         le_ff    <= 1'b0;
         mark_ff  <= 1'b0;
         above_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         case (ctl.op)
            OP_COMPARE: begin
               v_ff     <= valid;
               endgt_ff <= valid && (end_ff > ctl.addr);
               stlt_ff  <= valid && (start_ff < ctl.range_end);
               le_ff    <= valid && (start_ff <= ctl.addr);
            end
            OP_REPLACE: begin
               mark_ff  <= flags.ovl && lo_flags.ovl;
               above_ff <= v_ff && !stlt_ff;
            end
            OP_SHIFT: begin
               if (mark_ff || above_ff) begin
                  mark_ff  <= up_flags.mark;
                  above_ff <= up_flags.above;
               end
            end
            OP_SELECT: begin
               hit_ff <= le_ff && !up_flags.le && endgt_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (ctl.op)
         OP_INSERT: begin
            if (flags.pos) begin
               if (lo_flags.pos) begin
                  start_ff <= lo_start;
                  end_ff   <= lo_end;
                  id_ff    <= lo_id;
               end else begin
                  start_ff <= ctl.addr;
                  end_ff   <= ctl.range_end;
                  id_ff    <= tag;
               end
            end
         end
         OP_REPLACE: begin
            if (first_ovl) begin
               start_ff <= ctl.addr;
               end_ff   <= ctl.range_end;
               id_ff    <= tag;
            end
         end
         OP_SHIFT: begin
            if (mark_ff || above_ff) begin
               start_ff <= up_start;
               end_ff   <= up_end;
               id_ff    <= up_id;
            end
         end
         default: begin
         end
      endcase
   end

   assign range_start = start_ff;
   assign range_end   = end_ff;
   assign range_id    = id_ff;
   assign sel_hit     = hit_ff;
   assign sel_start   = hit_ff ? start_ff : '0;
   assign sel_end     = hit_ff ? end_ff : '0;
   assign sel_id      = hit_ff ? id_ff : '0;

endmodule

FILE: sv/sim_gather.sv
// ----------------------------------------------------------------------------
// sim_gather: registered collection of the matching entry
// Merges the masked entries of all cells in two registered levels of groups,
// so at most one entry, the one that holds the probe address, comes out.
// ----------------------------------------------------------------------------
module sim_gather #(
   parameter int DEPTH   = 64,
   parameter int ID_BITS = 16
) (
   input  logic               clock,
   input  logic [DEPTH-1:0]   cell_hit,
   input  logic [63:0]        cell_start [DEPTH],
   input  logic [63:0]        cell_end   [DEPTH],
   input  logic [ID_BITS-1:0] cell_id    [DEPTH],
   output logic               hit,
   output logic [63:0]        hit_start,
   output logic [63:0]        hit_end,
   output logic [ID_BITS-1:0] hit_id
);
   import sim_pkg::*;

   localparam int NG = (DEPTH + GATHER_GROUP - 1) / GATHER_GROUP;

   logic               grp_hit_ff   [NG];
   logic [63:0]        grp_start_ff [NG];
   logic [63:0]        grp_end_ff   [NG];
   logic [ID_BITS-1:0] grp_id_ff    [NG];
   logic               hit_ff;
   logic [63:0]        start_ff;
   logic [63:0]        end_ff;
   logic [ID_BITS-1:0] id_ff;

   always_ff @(posedge clock) begin
      for (int g = 0; g < NG; g++) begin
         logic               h;
         logic [63:0]        s;
         logic [63:0]        e;
         logic [ID_BITS-1:0] d;
         h = 1'b0;
         s = '0;
         e = '0;
         d = '0;
         for (int k = 0; k < GATHER_GROUP; k++) begin
            if (g * GATHER_GROUP + k < DEPTH) begin
               h = h | cell_hit[g * GATHER_GROUP + k];
               s = s | cell_start[g * GATHER_GROUP + k];
               e = e | cell_end[g * GATHER_GROUP + k];
               d = d | cell_id[g * GATHER_GROUP + k];
            end
         end
         grp_hit_ff[g]   <= h;
         grp_start_ff[g] <= s;
         grp_end_ff[g]   <= e;
         grp_id_ff[g]    <= d;
      end
   end

   always_ff @(posedge clock) begin
      logic               h;
      logic [63:0]        s;
      logic [63:0]        e;
      logic [ID_BITS-1:0] d;
      h = 1'b0;
      s = '0;
      e = '0;
      d = '0;
      for (int g = 0; g < NG; g++) begin
         h = h | grp_hit_ff[g];
         s = s | grp_start_ff[g];
         e = e | grp_end_ff[g];
         d = d | grp_id_ff[g];
      end
      hit_ff   <= h;
      start_ff <= s;
      end_ff   <= e;
      id_ff    <= d;
   end

   assign hit       = hit_ff;
   assign hit_start = start_ff;
   assign hit_end   = end_ff;
   assign hit_id    = id_ff;

endmodule

FILE: sv/sorted_interval_map.sv
// ----------------------------------------------------------------------------
// sorted_interval_map: sorted table of address ranges with lookup
// Keeps up to DEPTH half-open ranges in start order, one per cell, adds
// ranges with overlap replacement and returns the range holding an address.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  req_     in   tuser: request kind; tdata: address, length, module_id
//  rsp_     out  tuser: status; tdata: hit_base, hit_size, hit_id, removed_count
//
//  A lookup passes through compare, select, two gather levels, the result register
//  and the idle state before the next transfer. An insert or a refused add passes
//  through compare, decide and the result register; a replacing add also runs the
//  shift state, where the table compacts by one cell per cycle until every entry it
//  removes beyond the replaced one is gone. The table is empty after reset. A stalled
//  response holds the block in its final state until the response is taken.
// ----------------------------------------------------------------------------
module sorted_interval_map #(
   parameter int DEPTH   = 64,
   parameter int ID_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,  // address[63:0], length[95:64], module_id[111:96]
   input  logic         req_tuser,  // request kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,  // hit_base, hit_size, hit_id, removed_count, pad
   output logic [2:0]   rsp_tuser   // status
);
   import sim_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_COMPARE,
      S_DECIDE,
      S_SHIFT,
      S_GATHER1,
      S_GATHER2,
      S_FINISH
   } state_type;

   state_type          state_ff;
   logic               type_ff;
   logic [63:0]        addr_ff;
   logic [63:0]        end_ff;
   logic [ID_BITS-1:0] tag_ff;
   logic               ovf_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      steps_ff;
   logic [2:0]         res_status_ff;
   logic [6:0]         res_removed_ff;
   logic               rsp_tvalid_ff;
   logic [119:0]       rsp_tdata_ff;
   logic [2:0]         rsp_tuser_ff;

   logic [64:0]        end_in;
   logic [CW:0]        removed_sum;
   cell_ctl_type       ctl;
   cell_flags_type     flags_w   [DEPTH];
   cell_flags_type     lo_flags_w[DEPTH];
   cell_flags_type     up_flags_w[DEPTH];
   logic [63:0]        start_w   [DEPTH];
   logic [63:0]        rend_w    [DEPTH];
   logic [ID_BITS-1:0] id_w      [DEPTH];
   logic [63:0]        lo_start_w[DEPTH];
   logic [63:0]        lo_end_w  [DEPTH];
   logic [ID_BITS-1:0] lo_id_w   [DEPTH];
   logic [63:0]        up_start_w[DEPTH];
   logic [63:0]        up_end_w  [DEPTH];
   logic [ID_BITS-1:0] up_id_w   [DEPTH];
   logic [DEPTH-1:0]   hit_vec;
   logic [63:0]        sel_start_w[DEPTH];
   logic [63:0]        sel_end_w  [DEPTH];
   logic [ID_BITS-1:0] sel_id_w   [DEPTH];
   logic [DEPTH-1:0]   ovl_vec;
   logic [DEPTH-1:0]   mark_vec;
   logic               any_ovl;
   logic               any_mark;
   logic               table_full;
   logic               g_hit;
   logic [63:0]        g_start;
   logic [63:0]        g_end;
   logic [ID_BITS-1:0] g_id;
   logic [31:0]        g_size;

   assign end_in      = {1'b0, req_tdata[63:0]} + {33'b0, req_tdata[95:64]};
   assign removed_sum = {1'b0, steps_ff} + (CW+1)'(1);
   assign table_full  = count_ff == CW'(DEPTH);
   assign any_ovl     = |ovl_vec;
   assign any_mark    = |mark_vec;
   assign g_size      = g_end[31:0] - g_start[31:0];

   always_comb begin
      ctl.addr      = addr_ff;
      ctl.range_end = end_ff;
      ctl.op        = OP_HOLD;
      case (state_ff)
         S_COMPARE: ctl.op = OP_COMPARE;
         S_DECIDE: begin
            if (type_ff == REQ_LOOKUP) begin
               ctl.op = OP_SELECT;
            end else if (!ovf_ff) begin
               if (any_ovl) begin
                  ctl.op = OP_REPLACE;
               end else if (!table_full) begin
                  ctl.op = OP_INSERT;
               end
            end
         end
         S_SHIFT: begin
            if (any_mark) begin
               ctl.op = OP_SHIFT;
            end
         end
         default: ctl.op = OP_HOLD;
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_lo_edge
         assign lo_flags_w[i] = '0;
         assign lo_start_w[i] = '0;
         assign lo_end_w[i]   = '0;
         assign lo_id_w[i]    = '0;
      end else begin : g_lo_link
         assign lo_flags_w[i] = flags_w[i-1];
         assign lo_start_w[i] = start_w[i-1];
         assign lo_end_w[i]   = rend_w[i-1];
         assign lo_id_w[i]    = id_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_up_edge
         assign up_flags_w[i] = '0;
         assign up_start_w[i] = '0;
         assign up_end_w[i]   = '0;
         assign up_id_w[i]    = '0;
      end else begin : g_up_link
         assign up_flags_w[i] = flags_w[i+1];
         assign up_start_w[i] = start_w[i+1];
         assign up_end_w[i]   = rend_w[i+1];
         assign up_id_w[i]    = id_w[i+1];
      end

      assign ovl_vec[i]  = flags_w[i].ovl;
      assign mark_vec[i] = flags_w[i].mark;

      sim_cell #(
         .IDX     (i),
         .ID_BITS (ID_BITS),
         .CW      (CW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .tag         (tag_ff),
         .count       (count_ff),
         .lo_flags    (lo_flags_w[i]),
         .lo_start    (lo_start_w[i]),
         .lo_end      (lo_end_w[i]),
         .lo_id       (lo_id_w[i]),
         .up_flags    (up_flags_w[i]),
         .up_start    (up_start_w[i]),
         .up_end      (up_end_w[i]),
         .up_id       (up_id_w[i]),
         .flags       (flags_w[i]),
         .range_start (start_w[i]),
         .range_end   (rend_w[i]),
         .range_id    (id_w[i]),
         .sel_hit     (hit_vec[i]),
         .sel_start   (sel_start_w[i]),
         .sel_end     (sel_end_w[i]),
         .sel_id      (sel_id_w[i])
      );
   end

   sim_gather #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS)
   ) u_gather (
      .clock      (clock),
      .cell_hit   (hit_vec),
      .cell_start (sel_start_w),
      .cell_end   (sel_end_w),
      .cell_id    (sel_id_w),
      .hit        (g_hit),
      .hit_start  (g_start),
      .hit_end    (g_end),
      .hit_id     (g_id)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         steps_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && state_ff != S_FINISH) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  type_ff  <= req_tuser;
                  addr_ff  <= req_tdata[63:0];
                  end_ff   <= end_in[63:0];
                  ovf_ff   <= end_in[64];
                  tag_ff   <= ID_BITS'(req_tdata[111:96]);
                  state_ff <= S_COMPARE;
               end
            end
            S_COMPARE: state_ff <= S_DECIDE;
            S_DECIDE: begin
               res_removed_ff <= '0;
               if (type_ff == REQ_LOOKUP) begin
                  state_ff <= S_GATHER1;
               end else if (ovf_ff) begin
                  res_status_ff <= ST_OVERFLOW;
                  state_ff      <= S_FINISH;
               end else if (any_ovl) begin
                  steps_ff <= '0;
                  state_ff <= S_SHIFT;
               end else if (table_full) begin
                  res_status_ff <= ST_FULL;
                  state_ff      <= S_FINISH;
               end else begin
                  count_ff      <= count_ff + CW'(1);
                  res_status_ff <= ST_INSERTED;
                  state_ff      <= S_FINISH;
               end
            end
            S_SHIFT: begin
               if (any_mark) begin
                  count_ff <= count_ff - CW'(1);
                  steps_ff <= steps_ff + CW'(1);
               end else begin
                  res_status_ff  <= ST_REPLACED;
                  res_removed_ff <= 7'(removed_sum);
                  state_ff       <= S_FINISH;
               end
            end
            S_GATHER1: state_ff <= S_GATHER2;
            S_GATHER2: state_ff <= S_FINISH;
            S_FINISH: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  if (type_ff == REQ_LOOKUP) begin
                     rsp_tuser_ff <= g_hit ? ST_HIT : ST_MISS;
                     rsp_tdata_ff <= {1'b0, 7'd0, 16'(g_id), g_size, g_start};
                  end else begin
                     rsp_tuser_ff <= res_status_ff;
                     rsp_tdata_ff <= {1'b0, res_removed_ff, 16'd0, 32'd0, 64'd0};
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds table depth");

   a_shift_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && any_mark) |=> count_ff == CW'($past(count_ff) - CW'(1)))
      else $error("compaction step did not drop one entry");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GATHER1 |-> $onehot0(hit_vec))
      else $error("more than one cell claims the probe address");

endmodule
